@@ rtl/core/tsip_pkg.sv @@
package tsip_pkg;

	localparam int FRACTION_BITS = 20;
	localparam int MAG_W = 30 + FRACTION_BITS;
	localparam int BODY_N = 11;

	localparam logic [7:0] CH_DLE = 8'h10;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] ID_TIME = 8'h41;
	localparam logic [7:0] ID_VERSION = 8'h45;
	localparam logic [7:0] ID_HEALTH = 8'h46;
	localparam logic [7:0] HEALTH_NEEDS_RESET = 8'h02;
	localparam logic [19:0] WEEK_SECONDS = 20'd604800;
	localparam logic [28:0] EPOCH_OFFSET = 29'd315964800;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_INIT = 2'd1,
		OP_REQ  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_INIT = 2'd0,
		K_REQ  = 2'd1,
		K_PKT  = 2'd2,
		K_FERR = 2'd3
	} kind_t;

	localparam logic [2:0] EV_HANDLED = 3'd0;
	localparam logic [2:0] EV_REFUSED = 3'd1;
	localparam logic [2:0] EV_REQ_SENT = 3'd2;
	localparam logic [2:0] EV_TIME_OK = 3'd3;
	localparam logic [2:0] EV_TIME_FAIL = 3'd4;
	localparam logic [2:0] EV_INIT = 3'd5;
	localparam logic [2:0] EV_FRAME_ERR = 3'd6;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_TIME_REQ = 2'd2;
	localparam logic [1:0] CMD_INIT = 2'd3;

	localparam logic [2:0] RX_PREINIT = 3'd0;
	localparam logic [2:0] RX_RESET = 3'd1;
	localparam logic [2:0] RX_SEARCH = 3'd2;
	localparam logic [2:0] RX_READY = 3'd3;
	localparam logic [2:0] RX_QUERY = 3'd4;

	localparam logic [2:0] FLT_OK = 3'd0;
	localparam logic [2:0] FLT_RESET = 3'd1;
	localparam logic [2:0] FLT_SHORT = 3'd2;
	localparam logic [2:0] FLT_OPEN = 3'd3;
	localparam logic [2:0] FLT_BATTERY = 3'd4;

	typedef struct packed {
		kind_t kind;
		logic [BODY_N-1:0][7:0] body;
	} entry_t;

endpackage

@@ rtl/core/gps_tsip_time_receiver.sv @@
// TSIP time receiver. Each input item is a receiver byte (s_tuser = 0), an
// init command (1) or a host time request (2); opcode 3 is ignored. A front
// deframer strips DLE stuffing, finds packet ends and pushes init, request,
// packet-end and framing-error work into a four-entry queue; a back engine
// tracks receiver state and fault and writes one result per queued job into
// an output register. Bytes are taken every cycle as long as the queue has
// room. A time packet in query state runs through a three-stage float-to-fixed,
// add and scale path in the back engine, during which the queue holds further
// work; every other job writes its result as it is popped. Bytes before the
// first init command are dropped with no result.
// indoor_mode is held for the init sequence and does not change any result.
module gps_tsip_time_receiver import tsip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data,   // [0] indoor_mode
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,    // [7:0] gps_byte
	input  logic [7:0] s_tuser,    // [1:0] opcode
	output logic m_tvalid,
	input  logic m_tready,
	output logic [71:0] m_tdata,   // command, receiver_status, fault, packet_id,
	                               // utc_seconds, utc_microseconds
	output logic [7:0] m_tuser     // [2:0] event_res
);

	logic indoor_mode_q;
	logic push, pop, full, empty;
	entry_t push_data, head;
	logic [2:0] ev;

	// hold the sensitivity choice for the init sequence
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indoor_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			indoor_mode_q <= cfg_data[0] | (indoor_mode_q & 1'b0);
		end
	end

	tsip_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_op(s_tuser[1:0]), .in_byte(s_tdata),
		.in_ready(s_tready), .push(push), .push_data(push_data), .full(full)
	);

	tsip_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .empty(empty), .pop_data(head)
	);

	tsip_back u_back (
		.clk(clk), .arst_n(arst_n),
		.empty(empty), .head(head), .pop(pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_event(ev), .out_data(m_tdata)
	);

	assign m_tuser = {5'd0, ev};

endmodule

@@ rtl/core/tsip_front.sv @@
module tsip_front import tsip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [1:0] in_op,
	input  logic [7:0] in_byte,
	output logic in_ready,
	output logic push,
	output entry_t push_data,
	input  logic full
);

	typedef enum logic [1:0] {FR_IDLE, FR_START, FR_BODY, FR_ESC} fr_t;

	fr_t fr_q, fr_n;
	logic init_q, init_n;
	logic [BODY_N-1:0][7:0] body_q, body_n;
	logic [3:0] cnt_q, cnt_n;
	logic acc;

	assign in_ready = !full;
	assign acc = in_valid && !full;

	always_comb begin
		fr_n = fr_q;
		init_n = init_q;
		body_n = body_q;
		cnt_n = cnt_q;
		push = 1'b0;
		push_data.kind = K_PKT;
		push_data.body = body_q;
		if (acc) begin
			case (op_t'(in_op))
				OP_INIT: begin
					fr_n = FR_IDLE;
					init_n = 1'b1;
					push = 1'b1;
					push_data.kind = K_INIT;
				end
				OP_REQ: begin
					push = 1'b1;
					push_data.kind = K_REQ;
				end
				OP_BYTE: begin
					if (init_q) begin
						unique case (fr_q)
							FR_IDLE: begin
								if (in_byte == CH_DLE) begin
									fr_n = FR_START;
								end else begin
									push = 1'b1;
									push_data.kind = K_FERR;
								end
							end
							FR_START: begin
								if (in_byte == CH_ETX) begin
									fr_n = FR_IDLE;
									push = 1'b1;
									push_data.kind = K_FERR;
								end else begin
									body_n = '0;
									body_n[0] = in_byte;
									cnt_n = 4'd1;
									fr_n = FR_BODY;
								end
							end
							FR_BODY: begin
								if (in_byte == CH_DLE) begin
									fr_n = FR_ESC;
								end else if (cnt_q < 4'(BODY_N)) begin
									body_n[cnt_q] = in_byte;
									cnt_n = cnt_q + 4'd1;
								end
							end
							FR_ESC: begin
								if (in_byte == CH_ETX) begin
									fr_n = FR_IDLE;
									push = 1'b1;
									push_data.kind = K_PKT;
								end else begin
									fr_n = FR_BODY;
									// lone DLE keeps itself, then the byte after it
									if (cnt_q < 4'(BODY_N)) begin
										body_n[cnt_q] = CH_DLE;
										cnt_n = cnt_q + 4'd1;
										if (in_byte != CH_DLE && cnt_q < 4'(BODY_N - 1)) begin
											body_n[cnt_q + 4'd1] = in_byte;
											cnt_n = cnt_q + 4'd2;
										end
									end
								end
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_q <= FR_IDLE;
			init_q <= 1'b0;
			cnt_q <= '0;
			body_q <= '0;
		end else begin
			fr_q <= fr_n;
			init_q <= init_n;
			cnt_q <= cnt_n;
			body_q <= body_n;
		end
	end

endmodule

@@ rtl/core/tsip_queue.sv @@
module tsip_queue import tsip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  entry_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output entry_t pop_data
);

	entry_t mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

@@ rtl/core/tsip_back.sv @@
module tsip_back import tsip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  entry_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] out_event,
	output logic [71:0] out_data
);

	typedef enum logic [1:0] {B_RUN, B_T1, B_T2, B_T3} bst_t;

	localparam logic [63:0] LIM64 = (64'd1 << MAG_W) - 64'd1;
	localparam int SUM_W = MAG_W + 2;
	localparam int WHOLE_W = SUM_W - FRACTION_BITS;

	function automatic logic signed [MAG_W:0] to_fixed(input logic [31:0] w);
		logic [7:0] e;
		logic [23:0] m;
		logic signed [9:0] s;
		logic [63:0] sh;
		logic [MAG_W-1:0] mag;
		e = w[30:23];
		m = {1'b0, w[22:0]};
		if (e == 8'd0) e = 8'd1;
		else m[23] = 1'b1;
		s = $signed({2'b00, e}) - 10'sd150 + 10'(FRACTION_BITS);
		sh = '0;
		if (w[30:23] == 8'hFF) begin
			mag = LIM64[MAG_W-1:0];
		end else if (!s[9]) begin
			if (s > 10'sd40) begin
				mag = LIM64[MAG_W-1:0];
			end else begin
				sh = {40'd0, m} << s[5:0];
				mag = (sh > LIM64) ? LIM64[MAG_W-1:0] : sh[MAG_W-1:0];
			end
		end else begin
			sh = {40'd0, m} >> (-s);
			mag = sh[MAG_W-1:0];
		end
		return w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	bst_t st_q;
	logic [2:0] phase_q, fault_q;
	logic [BODY_N-1:0][7:0] tb_q;
	logic [7:0] tid_q;
	logic signed [MAG_W:0] fa_s1, fb_s1;
	logic [35:0] wk_s1, wk_s2;
	logic signed [WHOLE_W-1:0] whole_s2;
	logic [FRACTION_BITS-1:0] frac_s2;
	logic slot;
	logic load_out;

	logic [2:0] ph_n, fl_n, ev_n;
	logic [1:0] cmd_n;
	logic [7:0] id, b1, b2;
	logic to_time;
	logic signed [SUM_W-1:0] sum;
	logic signed [37:0] total;
	logic [FRACTION_BITS+19:0] uprod;

	assign slot = !out_valid || out_ready;
	assign pop = (st_q == B_RUN) && !empty && slot;
	assign load_out = (pop && !to_time) || (st_q == B_T3 && slot);
	assign id = head.body[0];
	assign b1 = head.body[1];
	assign b2 = head.body[2];

	always_comb begin
		ph_n = phase_q;
		fl_n = fault_q;
		ev_n = EV_HANDLED;
		cmd_n = CMD_NONE;
		to_time = 1'b0;
		case (head.kind)
			K_INIT: begin
				ph_n = RX_RESET;
				ev_n = EV_INIT;
				cmd_n = CMD_INIT;
			end
			K_REQ: begin
				if (phase_q == RX_READY && fault_q == FLT_OK) begin
					ph_n = RX_QUERY;
					ev_n = EV_REQ_SENT;
					cmd_n = CMD_TIME_REQ;
				end else begin
					ev_n = EV_REFUSED;
				end
			end
			K_FERR: ev_n = EV_FRAME_ERR;
			default: begin
				if (id == ID_HEALTH) begin
					if (b1 == HEALTH_NEEDS_RESET) begin
						cmd_n = CMD_RESET;
						if (phase_q == RX_QUERY) ev_n = EV_TIME_FAIL;
						fl_n = FLT_RESET;
						ph_n = RX_RESET;
					end else begin
						fl_n = FLT_OK;
					end
					if (b2[7:4] == 4'd3) fl_n = FLT_SHORT;
					else if (b2[7:4] == 4'd1) fl_n = FLT_OPEN;
					else if (b2[0]) fl_n = FLT_BATTERY;
				end
				unique case (ph_n)
					RX_RESET: if (id == ID_VERSION) ph_n = RX_SEARCH;
					RX_SEARCH: if (id == ID_HEALTH && b1 == 8'd0) ph_n = RX_READY;
					RX_READY: if (id == ID_HEALTH && b1 != 8'd0) ph_n = RX_SEARCH;
					RX_QUERY: begin
						if (id == ID_HEALTH && b1 != 8'd0) begin
							ph_n = RX_SEARCH;
							ev_n = EV_TIME_FAIL;
						end else if (id == ID_TIME) begin
							ph_n = RX_READY;
							to_time = 1'b1;
						end
					end
					default: ;
				endcase
			end
		endcase
	end

	assign sum = SUM_W'(fa_s1) + SUM_W'(fb_s1);
	assign total = $signed(38'(EPOCH_OFFSET)) + $signed({2'b00, wk_s2}) + 38'(whole_s2);
	assign uprod = (FRACTION_BITS+20)'(frac_s2) * (FRACTION_BITS+20)'(USEC_PER_SEC);

	always_ff @(posedge clk) begin
		if (pop && to_time) begin
			tb_q <= head.body;
			tid_q <= id;
		end
		fa_s1 <= to_fixed({tb_q[1], tb_q[2], tb_q[3], tb_q[4]});
		fb_s1 <= to_fixed({tb_q[7], tb_q[8], tb_q[9], tb_q[10]});
		wk_s1 <= 36'({tb_q[5], tb_q[6]}) * 36'(WEEK_SECONDS);
		whole_s2 <= sum[SUM_W-1:FRACTION_BITS];
		frac_s2 <= sum[FRACTION_BITS-1:0];
		wk_s2 <= wk_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_RUN;
			phase_q <= RX_PREINIT;
			fault_q <= FLT_OK;
			out_valid <= 1'b0;
			out_event <= '0;
			out_data <= '0;
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (st_q)
				B_RUN: begin
					if (pop) begin
						phase_q <= ph_n;
						fault_q <= fl_n;
						if (to_time) begin
							st_q <= B_T1;
						end else begin
							out_event <= ev_n;
							out_data <= {20'd0, 36'd0,
								(head.kind == K_PKT) ? id : 8'd0, fl_n, ph_n, cmd_n};
						end
					end
				end
				B_T1: st_q <= B_T2;
				B_T2: st_q <= B_T3;
				B_T3: begin
					if (slot) begin
						st_q <= B_RUN;
						out_event <= EV_TIME_OK;
						if (total < 0) begin
							out_data <= {20'd0, 36'd0, tid_q, fault_q, phase_q, CMD_NONE};
						end else begin
							out_data <= {uprod[FRACTION_BITS+19:FRACTION_BITS], total[35:0],
								tid_q, fault_q, phase_q, CMD_NONE};
						end
					end
				end
			endcase
		end
	end

	a_no_preinit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(phase_q) != RX_PREINIT |-> phase_q != RX_PREINIT)
		else $error("receiver returned to pre-init");
	a_time_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_event == EV_TIME_OK |-> out_data[4:2] == RX_READY)
		else $error("time result without ready status");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != B_RUN |-> !pop)
		else $error("queue popped during time conversion");
	a_t1_entry: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_T1 |-> $past(st_q) == B_RUN && $past(pop))
		else $error("time conversion started without a packet");

endmodule
